>>> rtl/i2csbf_pkg.sv
// Shared constants, types and helpers for the I2C slave with byte FIFOs.
package i2csbf_pkg;

    localparam int FIFO_ENTRIES = 16;
    localparam int ADDR_BITS    = 7;
    localparam int BYTE_BITS    = 8;
    localparam int PTR_W        = (FIFO_ENTRIES > 1) ? $clog2(FIFO_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(FIFO_ENTRIES + 1);
    localparam int SUM_W        = CNT_W + 1;
    localparam int LEVEL_W      = 5;
    localparam int PHASE_W      = 3;
    localparam int BITS_W       = 4;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_FLUSH = 3'd2,
        OP_SCL   = 3'd3,
        OP_SDA   = 3'd4
    } op_t;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_ADDR = 6'b000010,
        PH_RW   = 6'b000100,
        PH_ACK1 = 6'b001000,
        PH_DATA = 6'b010000,
        PH_ACK2 = 6'b100000
    } phase_t;

    localparam logic [PHASE_W-1:0] PHC_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PHC_ADDR = 3'd1;
    localparam logic [PHASE_W-1:0] PHC_RW   = 3'd2;
    localparam logic [PHASE_W-1:0] PHC_ACK1 = 3'd3;
    localparam logic [PHASE_W-1:0] PHC_DATA = 3'd4;
    localparam logic [PHASE_W-1:0] PHC_ACK2 = 3'd5;

    // Status of one result beat, minus the popped byte.
    typedef struct packed {
        logic                 pop_pend;
        logic                 pull_low;
        logic                 rx_empty;
        logic                 rx_full;
        logic                 tx_empty;
        logic                 tx_full;
        logic [LEVEL_W-1:0]   rx_level;
        logic [LEVEL_W-1:0]   tx_level;
        logic [PHASE_W-1:0]   bus_phase;
    } res_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_IDLE: code = PHC_IDLE;
            PH_ADDR: code = PHC_ADDR;
            PH_RW:   code = PHC_RW;
            PH_ACK1: code = PHC_ACK1;
            PH_DATA: code = PHC_DATA;
            PH_ACK2: code = PHC_ACK2;
            default: code = PHC_IDLE;
        endcase
        return code;
    endfunction

    // Slot at head + count, wrapped once; the slot is only written while count is below the depth.
    function automatic logic [PTR_W-1:0] ptr_wrap(input logic [PTR_W-1:0] head,
                                                  input logic [CNT_W-1:0] cnt);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(cnt);
        if (sum >= SUM_W'(FIFO_ENTRIES))
        begin
            sum = sum - SUM_W'(FIFO_ENTRIES);
        end
        return PTR_W'(sum);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] head);
        logic [PTR_W-1:0] nxt;
        if (head == PTR_W'(FIFO_ENTRIES - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = head + PTR_W'(1);
        end
        return nxt;
    endfunction

endpackage

>>> rtl/i2c_slave_with_byte_fifos.sv
// I2C slave bus engine with TX and RX byte FIFOs held in synchronous memories.
//
// Every beat on the input channel is one event: a CPU push, a CPU pop, a flush,
// or a new SCL or SDA level (other codes change nothing); each gives exactly
// one result beat. One event is accepted per clock cycle unless in_stall is
// high. The FIFO memories have a registered read port, so the popped byte and a
// TX byte loaded for sending come from a read register, and an output register
// follows. A byte loaded for sending is forwarded from the read register to the
// next event, so line events may follow each other back to back. The FIFO
// memories are not cleared after reset; only written entries are ever read.
// own_address must be written through cfg_write and cfg_data while no event
// is in flight; the block itself does not enforce this.
module i2c_slave_with_byte_fifos
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [7:0]  push_byte,
    input  logic        line_level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  popped_byte,
    output logic        sda_pull_low,
    output logic        rx_empty,
    output logic        rx_full,
    output logic        tx_empty,
    output logic        tx_full,
    output logic [4:0]  rx_level,
    output logic [4:0]  tx_level,
    output logic [2:0]  bus_phase
);

    localparam int PTR_W  = i2csbf_pkg::PTR_W;
    localparam int CNT_W  = i2csbf_pkg::CNT_W;
    localparam int BITS_W = i2csbf_pkg::BITS_W;

    // FIFO memories
    logic [7:0] tx_mem [i2csbf_pkg::FIFO_ENTRIES];
    logic [7:0] rx_mem [i2csbf_pkg::FIFO_ENTRIES];
    logic [7:0] tx_rd_reg;
    logic [7:0] rx_rd_reg;

    logic             tx_we, tx_re, rx_we, rx_re;
    logic [PTR_W-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
    logic [7:0]       rx_wdata;

    // Control state
    logic [6:0]             own_address_reg;
    logic [CNT_W-1:0]       tx_count_reg, tx_count_next;
    logic [CNT_W-1:0]       rx_count_reg, rx_count_next;
    logic [PTR_W-1:0]       tx_head_reg, tx_head_next;
    logic [PTR_W-1:0]       rx_head_reg, rx_head_next;
    i2csbf_pkg::phase_t     phase_reg, phase_next;
    logic [7:0]             shift_byte_reg, shift_byte_next, shift_eff;
    logic                   tx_pend_reg, tx_pend_next;
    logic [BITS_W-1:0]      bits_left_reg, bits_left_next;
    logic [6:0]             heard_address_reg, heard_address_next;
    logic                   is_read_reg, is_read_next;
    logic                   scl_seen_reg, scl_seen_next;
    logic                   sda_seen_reg, sda_seen_next;
    logic                   drive_low_reg, drive_low_next;

    // Result pipeline
    logic               s1_valid_reg, s1_valid_next;
    i2csbf_pkg::res_t   s1_res_reg, s1_res_next;
    logic               out_valid_reg, out_valid_next;
    i2csbf_pkg::res_t   out_res_reg;
    logic [7:0]         out_byte_reg;

    logic accept, s1_move, pop_pend;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // A TX byte read last beat is still in the read register
    assign shift_eff = tx_pend_reg ? tx_rd_reg : shift_byte_reg;

    always_comb
    begin
        tx_count_next      = tx_count_reg;
        rx_count_next      = rx_count_reg;
        tx_head_next       = tx_head_reg;
        rx_head_next       = rx_head_reg;
        phase_next         = phase_reg;
        shift_byte_next    = shift_byte_reg;
        tx_pend_next       = tx_pend_reg;
        bits_left_next     = bits_left_reg;
        heard_address_next = heard_address_reg;
        is_read_next       = is_read_reg;
        scl_seen_next      = scl_seen_reg;
        sda_seen_next      = sda_seen_reg;
        drive_low_next     = drive_low_reg;
        tx_we              = 1'b0;
        tx_re              = 1'b0;
        rx_we              = 1'b0;
        rx_re              = 1'b0;
        tx_waddr           = i2csbf_pkg::ptr_wrap(tx_head_reg, tx_count_reg);
        rx_waddr           = i2csbf_pkg::ptr_wrap(rx_head_reg, rx_count_reg);
        tx_raddr           = tx_head_reg;
        rx_raddr           = rx_head_reg;
        rx_wdata           = shift_eff;
        pop_pend           = 1'b0;

        if (accept)
        begin
            shift_byte_next = shift_eff;
            tx_pend_next    = 1'b0;
            case (operation)
                i2csbf_pkg::OP_PUSH:
                begin
                    if (tx_count_reg < CNT_W'(i2csbf_pkg::FIFO_ENTRIES))
                    begin
                        tx_we         = 1'b1;
                        tx_count_next = tx_count_reg + CNT_W'(1);
                    end
                end
                i2csbf_pkg::OP_POP:
                begin
                    if (rx_count_reg != '0)
                    begin
                        rx_re         = 1'b1;
                        pop_pend      = 1'b1;
                        rx_head_next  = i2csbf_pkg::ptr_inc(rx_head_reg);
                        rx_count_next = rx_count_reg - CNT_W'(1);
                    end
                end
                i2csbf_pkg::OP_FLUSH:
                begin
                    tx_count_next = '0;
                    rx_count_next = '0;
                    tx_head_next  = '0;
                    rx_head_next  = '0;
                end
                i2csbf_pkg::OP_SCL:
                begin
                    scl_seen_next = line_level;
                    if (!scl_seen_reg && line_level)
                    begin
                        case (phase_reg)
                            i2csbf_pkg::PH_ADDR:
                            begin
                                heard_address_next = {heard_address_reg[5:0], sda_seen_reg};
                                bits_left_next     = bits_left_reg - BITS_W'(1);
                                if (bits_left_next == '0)
                                begin
                                    phase_next = i2csbf_pkg::PH_RW;
                                end
                            end
                            i2csbf_pkg::PH_RW:
                            begin
                                is_read_next = sda_seen_reg;
                                phase_next   = (heard_address_reg == own_address_reg) ?
                                               i2csbf_pkg::PH_ACK1 : i2csbf_pkg::PH_IDLE;
                            end
                            i2csbf_pkg::PH_DATA:
                            begin
                                if (!is_read_reg)
                                begin
                                    shift_byte_next = {shift_eff[6:0], sda_seen_reg};
                                    bits_left_next  = bits_left_reg - BITS_W'(1);
                                    if (bits_left_next == '0)
                                    begin
                                        rx_wdata   = shift_byte_next;
                                        phase_next = i2csbf_pkg::PH_ACK2;
                                        if (rx_count_reg < CNT_W'(i2csbf_pkg::FIFO_ENTRIES))
                                        begin
                                            rx_we         = 1'b1;
                                            rx_count_next = rx_count_reg + CNT_W'(1);
                                        end
                                    end
                                end
                                else if (bits_left_reg == '0)
                                begin
                                    phase_next = i2csbf_pkg::PH_ACK2;
                                end
                            end
                            i2csbf_pkg::PH_ACK1, i2csbf_pkg::PH_ACK2:
                            begin
                                // Master NACK after a read byte ends the transfer
                                if (phase_reg == i2csbf_pkg::PH_ACK2 && is_read_reg &&
                                    sda_seen_reg)
                                begin
                                    phase_next = i2csbf_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    phase_next      = i2csbf_pkg::PH_DATA;
                                    bits_left_next  = BITS_W'(i2csbf_pkg::BYTE_BITS);
                                    shift_byte_next = '0;
                                    if (is_read_reg && tx_count_reg != '0)
                                    begin
                                        tx_re         = 1'b1;
                                        tx_pend_next  = 1'b1;
                                        tx_head_next  = i2csbf_pkg::ptr_inc(tx_head_reg);
                                        tx_count_next = tx_count_reg - CNT_W'(1);
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else if (scl_seen_reg && !line_level)
                    begin
                        if (phase_reg == i2csbf_pkg::PH_DATA && is_read_reg)
                        begin
                            if (bits_left_reg != '0)
                            begin
                                bits_left_next = bits_left_reg - BITS_W'(1);
                                drive_low_next = ~shift_eff[bits_left_next[2:0]];
                            end
                        end
                        else if (phase_reg == i2csbf_pkg::PH_ACK1)
                        begin
                            drive_low_next = 1'b1;
                        end
                        else if (phase_reg == i2csbf_pkg::PH_ACK2)
                        begin
                            drive_low_next = !is_read_reg;
                        end
                        else
                        begin
                            drive_low_next = 1'b0;
                        end
                    end
                end
                i2csbf_pkg::OP_SDA:
                begin
                    sda_seen_next = line_level;
                    if (scl_seen_reg)
                    begin
                        if (!sda_seen_reg && line_level)
                        begin
                            // STOP
                            phase_next     = i2csbf_pkg::PH_IDLE;
                            drive_low_next = 1'b0;
                        end
                        else if (sda_seen_reg && !line_level)
                        begin
                            // START
                            heard_address_next = '0;
                            shift_byte_next    = '0;
                            bits_left_next     = BITS_W'(i2csbf_pkg::ADDR_BITS);
                            is_read_next       = 1'b0;
                            phase_next         = i2csbf_pkg::PH_ADDR;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        s1_res_next.pop_pend  = pop_pend;
        s1_res_next.pull_low  = drive_low_next;
        s1_res_next.rx_empty  = (rx_count_next == '0);
        s1_res_next.rx_full   = (rx_count_next >= CNT_W'(i2csbf_pkg::FIFO_ENTRIES));
        s1_res_next.tx_empty  = (tx_count_next == '0);
        s1_res_next.tx_full   = (tx_count_next >= CNT_W'(i2csbf_pkg::FIFO_ENTRIES));
        s1_res_next.rx_level  = i2csbf_pkg::LEVEL_W'(rx_count_next);
        s1_res_next.tx_level  = i2csbf_pkg::LEVEL_W'(tx_count_next);
        s1_res_next.bus_phase = i2csbf_pkg::phase_code(phase_next);
        s1_valid_next         = accept || (s1_valid_reg && !s1_move);
        out_valid_next        = s1_move || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_mem[tx_waddr] <= push_byte;
        end
        if (tx_re)
        begin
            tx_rd_reg <= tx_mem[tx_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_waddr] <= rx_wdata;
        end
        if (rx_re)
        begin
            rx_rd_reg <= rx_mem[rx_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg   <= '0;
            tx_count_reg      <= '0;
            rx_count_reg      <= '0;
            tx_head_reg       <= '0;
            rx_head_reg       <= '0;
            phase_reg         <= i2csbf_pkg::PH_IDLE;
            shift_byte_reg    <= '0;
            tx_pend_reg       <= 1'b0;
            bits_left_reg     <= '0;
            heard_address_reg <= '0;
            is_read_reg       <= 1'b0;
            scl_seen_reg      <= 1'b1;
            sda_seen_reg      <= 1'b1;
            drive_low_reg     <= 1'b0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                own_address_reg <= cfg_data;
            end
            tx_count_reg      <= tx_count_next;
            rx_count_reg      <= rx_count_next;
            tx_head_reg       <= tx_head_next;
            rx_head_reg       <= rx_head_next;
            phase_reg         <= phase_next;
            shift_byte_reg    <= shift_byte_next;
            tx_pend_reg       <= tx_pend_next;
            bits_left_reg     <= bits_left_next;
            heard_address_reg <= heard_address_next;
            is_read_reg       <= is_read_next;
            scl_seen_reg      <= scl_seen_next;
            sda_seen_reg      <= sda_seen_next;
            drive_low_reg     <= drive_low_next;
            s1_valid_reg      <= s1_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= s1_res_next;
        end
        if (s1_move)
        begin
            out_res_reg  <= s1_res_reg;
            out_byte_reg <= s1_res_reg.pop_pend ? rx_rd_reg : 8'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_byte  = out_byte_reg;
    assign sda_pull_low = out_res_reg.pull_low;
    assign rx_empty     = out_res_reg.rx_empty;
    assign rx_full      = out_res_reg.rx_full;
    assign tx_empty     = out_res_reg.tx_empty;
    assign tx_full      = out_res_reg.tx_full;
    assign rx_level     = out_res_reg.rx_level;
    assign tx_level     = out_res_reg.tx_level;
    assign bus_phase    = out_res_reg.bus_phase;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_count_reg <= CNT_W'(i2csbf_pkg::FIFO_ENTRIES)) &&
        (rx_count_reg <= CNT_W'(i2csbf_pkg::FIFO_ENTRIES)))
        else $error("FIFO count beyond depth");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room in the result pipeline");

    a_take_phase: assert property (@(posedge clk) disable iff (!rst_n)
        tx_pend_reg |-> (phase_reg == i2csbf_pkg::PH_DATA && is_read_reg))
        else $error("TX byte loaded outside a read data phase");

    // The loaded byte waits in the read register until the next accepted beat
    a_take_accept: assert property (@(posedge clk) disable iff (!rst_n)
        tx_pend_reg |-> $past(accept || tx_pend_reg))
        else $error("TX read pending without an accepted beat");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the I2C slave with transmit and receive byte FIFOs.
`timescale 1ns / 100ps

module testbench;

    localparam int         FIFO_ENTRIES   = i2csbf_pkg::FIFO_ENTRIES;
    localparam int         LEVEL_W        = i2csbf_pkg::LEVEL_W;
    localparam int         PHASE_W        = i2csbf_pkg::PHASE_W;
    localparam int         BYTE_BITS      = i2csbf_pkg::BYTE_BITS;
    localparam int         ADDR_BITS      = i2csbf_pkg::ADDR_BITS;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam int         SPARE_OPS      = 3;
    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [7:0]         popped;
        logic               pull;
        logic               rx_empty;
        logic               rx_full;
        logic               tx_empty;
        logic               tx_full;
        logic [LEVEL_W-1:0] rx_level;
        logic [LEVEL_W-1:0] tx_level;
        logic [PHASE_W-1:0] phase;
    } status_t;

    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
        logic       lv;
    } bus_event_t;

    // Tracks the slave and both FIFOs, and holds the status beats still due.
    class slave_status_tracker;
        logic [7:0]         tx_mem [FIFO_ENTRIES];
        logic [7:0]         rx_mem [FIFO_ENTRIES];
        int                 tx_cnt;
        int                 rx_cnt;
        int                 tx_rd;
        int                 rx_rd;
        logic [PHASE_W-1:0] ph;
        logic [7:0]         shreg;
        logic [3:0]         bits_left;
        logic [6:0]         addr_heard;
        logic [6:0]         own_addr;
        logic               rd_mode;
        logic               scl;
        logic               sda;
        logic               pull;
        status_t            status_due[$];
        int                 errors;
        int                 checked;

        function new();
            tx_cnt     = 0;
            rx_cnt     = 0;
            tx_rd      = 0;
            rx_rd      = 0;
            ph         = i2csbf_pkg::PHC_IDLE;
            shreg      = '0;
            bits_left  = '0;
            addr_heard = '0;
            own_addr   = '0;
            rd_mode    = 1'b0;
            scl        = 1'b1;
            sda        = 1'b1;
            pull       = 1'b0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_address(logic [6:0] a);
            own_addr = a;
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        // Underrun sends 0.
        function logic [7:0] take_tx();
            logic [7:0] v;
            v = '0;
            if (tx_cnt > 0)
            begin
                v      = tx_mem[tx_rd];
                tx_rd  = (tx_rd + 1) % FIFO_ENTRIES;
                tx_cnt--;
            end
            return v;
        endfunction

        // Drop the byte when the RX FIFO is full.
        function void put_rx(logic [7:0] v);
            if (rx_cnt < FIFO_ENTRIES)
            begin
                rx_mem[(rx_rd + rx_cnt) % FIFO_ENTRIES] = v;
                rx_cnt++;
            end
        endfunction

        function void on_rise();
            case (ph)
                i2csbf_pkg::PHC_ADDR:
                begin
                    addr_heard = {addr_heard[5:0], sda};
                    bits_left  = bits_left - 4'd1;
                    if (bits_left == 4'd0)
                        ph = i2csbf_pkg::PHC_RW;
                end
                i2csbf_pkg::PHC_RW:
                begin
                    rd_mode = sda;
                    ph      = (addr_heard == own_addr) ? i2csbf_pkg::PHC_ACK1
                                                       : i2csbf_pkg::PHC_IDLE;
                end
                i2csbf_pkg::PHC_ACK1:
                begin
                    ph        = i2csbf_pkg::PHC_DATA;
                    bits_left = 4'(BYTE_BITS);
                    shreg     = rd_mode ? take_tx() : 8'h00;
                end
                i2csbf_pkg::PHC_DATA:
                begin
                    if (!rd_mode)
                    begin
                        shreg     = {shreg[6:0], sda};
                        bits_left = bits_left - 4'd1;
                        if (bits_left == 4'd0)
                        begin
                            put_rx(shreg);
                            ph = i2csbf_pkg::PHC_ACK2;
                        end
                    end
                    else if (bits_left == 4'd0)
                    begin
                        ph = i2csbf_pkg::PHC_ACK2;
                    end
                end
                i2csbf_pkg::PHC_ACK2:
                begin
                    // Master ACK continues a read, NACK ends it; a write always goes on.
                    if (!rd_mode || !sda)
                    begin
                        ph        = i2csbf_pkg::PHC_DATA;
                        bits_left = 4'(BYTE_BITS);
                        shreg     = rd_mode ? take_tx() : 8'h00;
                    end
                    else
                    begin
                        ph = i2csbf_pkg::PHC_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void on_fall();
            if (ph == i2csbf_pkg::PHC_DATA && rd_mode)
            begin
                if (bits_left != 4'd0)
                begin
                    bits_left = bits_left - 4'd1;
                    pull      = ~shreg[bits_left];
                end
            end
            else if (ph == i2csbf_pkg::PHC_ACK1)
                pull = 1'b1;
            else if (ph == i2csbf_pkg::PHC_ACK2)
                pull = !rd_mode;
            else
                pull = 1'b0;
        endfunction

        function void note_event(logic [2:0] op, logic [7:0] data, logic lv);
            status_t s;
            logic    prev;
            s.popped = 8'h00;
            case (op)
                i2csbf_pkg::OP_PUSH:
                begin
                    if (tx_cnt < FIFO_ENTRIES)
                    begin
                        tx_mem[(tx_rd + tx_cnt) % FIFO_ENTRIES] = data;
                        tx_cnt++;
                    end
                end
                i2csbf_pkg::OP_POP:
                begin
                    if (rx_cnt > 0)
                    begin
                        s.popped = rx_mem[rx_rd];
                        rx_rd    = (rx_rd + 1) % FIFO_ENTRIES;
                        rx_cnt--;
                    end
                end
                i2csbf_pkg::OP_FLUSH:
                begin
                    tx_cnt = 0;
                    rx_cnt = 0;
                    tx_rd  = 0;
                    rx_rd  = 0;
                end
                i2csbf_pkg::OP_SCL:
                begin
                    prev = scl;
                    scl  = lv;
                    if (!prev && lv)
                        on_rise();
                    else if (prev && !lv)
                        on_fall();
                end
                i2csbf_pkg::OP_SDA:
                begin
                    prev = sda;
                    sda  = lv;
                    if (scl)
                    begin
                        if (!prev && lv)
                        begin
                            ph   = i2csbf_pkg::PHC_IDLE;
                            pull = 1'b0;
                        end
                        else if (prev && !lv)
                        begin
                            addr_heard = '0;
                            shreg      = '0;
                            bits_left  = 4'(ADDR_BITS);
                            rd_mode    = 1'b0;
                            ph         = i2csbf_pkg::PHC_ADDR;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            s.pull     = pull;
            s.rx_empty = (rx_cnt == 0);
            s.rx_full  = (rx_cnt >= FIFO_ENTRIES);
            s.tx_empty = (tx_cnt == 0);
            s.tx_full  = (tx_cnt >= FIFO_ENTRIES);
            s.rx_level = LEVEL_W'(rx_cnt);
            s.tx_level = LEVEL_W'(tx_cnt);
            s.phase    = ph;
            status_due.push_back(s);
        endfunction

        function string show(status_t s);
            return $sformatf("pop=%h pull=%b rxe=%b rxf=%b txe=%b txf=%b %s",
                             s.popped, s.pull, s.rx_empty, s.rx_full, s.tx_empty,
                             s.tx_full,
                             $sformatf("rxl=%0d txl=%0d ph=%0d",
                                       s.rx_level, s.tx_level, s.phase));
        endfunction

        function void flag(string what, string want, string got);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s\n  expected %s\n  actual   %s", what, want, got);
        endfunction

        function void check_status(status_t got);
            status_t want;
            string   bad;
            checked++;
            if (status_due.size() == 0)
            begin
                flag("result beat with nothing expected", "none", show(got));
                return;
            end
            want = status_due.pop_front();
            bad  = "";
            if (got.popped   !== want.popped)   bad = {bad, " popped_byte"};
            if (got.pull     !== want.pull)     bad = {bad, " sda_pull_low"};
            if (got.rx_empty !== want.rx_empty) bad = {bad, " rx_empty"};
            if (got.rx_full  !== want.rx_full)  bad = {bad, " rx_full"};
            if (got.tx_empty !== want.tx_empty) bad = {bad, " tx_empty"};
            if (got.tx_full  !== want.tx_full)  bad = {bad, " tx_full"};
            if (got.rx_level !== want.rx_level) bad = {bad, " rx_level"};
            if (got.tx_level !== want.tx_level) bad = {bad, " tx_level"};
            if (got.phase    !== want.phase)    bad = {bad, " bus_phase"};
            if (bad != "")
                flag($sformatf("beat %0d wrong:%s", checked, bad), show(want), show(got));
        endfunction
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_write  = 1'b0;
    logic [6:0] cfg_data   = '0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [2:0] operation  = '0;
    logic [7:0] push_byte  = '0;
    logic       line_level = 1'b0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [7:0] popped_byte;
    logic       sda_pull_low;
    logic       rx_empty;
    logic       rx_full;
    logic       tx_empty;
    logic       tx_full;
    logic [4:0] rx_level;
    logic [4:0] tx_level;
    logic [2:0] bus_phase;

    slave_status_tracker tracker = new();
    bus_event_t          event_q[$];
    logic                gen_scl      = 1'b1;
    logic                gen_sda      = 1'b1;
    logic [6:0]          cur_addr     = '0;
    int                  mix_pct      = 8;
    int                  clk_budget   = 0;
    int                  send_idle    = 0;
    int                  recv_idle    = 0;
    int                  cycles       = 0;
    int                  events_sent  = 0;
    int                  transfers    = 0;
    int                  reads        = 0;

    i2c_slave_with_byte_fifos u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .push_byte    (push_byte),
        .line_level   (line_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_byte  (popped_byte),
        .sda_pull_low (sda_pull_low),
        .rx_empty     (rx_empty),
        .rx_full      (rx_full),
        .tx_empty     (tx_empty),
        .tx_full      (tx_full),
        .rx_level     (rx_level),
        .tx_level     (tx_level),
        .bus_phase    (bus_phase)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still due", cycles, tracker.pending());
            $display("i2c_slave_with_byte_fifos regression: fail");
            $finish;
        end
    end

    // Result side: check the accepted beat, then pick the next stall.
    always @(posedge clk)
    begin
        status_t got;
        if (out_valid && !out_stall)
        begin
            got.popped   = popped_byte;
            got.pull     = sda_pull_low;
            got.rx_empty = rx_empty;
            got.rx_full  = rx_full;
            got.tx_empty = tx_empty;
            got.tx_full  = tx_full;
            got.rx_level = rx_level;
            got.tx_level = tx_level;
            got.phase    = bus_phase;
            tracker.check_status(got);
        end
        out_stall <= rst_n && ($urandom_range(99) < recv_idle);
    end

    task automatic add_event(logic [2:0] op, logic [7:0] data, logic lv);
        bus_event_t e;
        e.op   = op;
        e.data = data;
        e.lv   = lv;
        event_q.push_back(e);
        if (op == i2csbf_pkg::OP_SCL)
            gen_scl = lv;
        else if (op == i2csbf_pkg::OP_SDA)
            gen_sda = lv;
    endtask

    task automatic set_sda(logic lv);
        if (gen_sda != lv)
            add_event(i2csbf_pkg::OP_SDA, 8'($urandom), lv);
    endtask

    task automatic cpu_burst(logic [2:0] op, int n);
        for (int k = 0; k < n; k++)
            add_event(op, 8'($urandom), 1'($urandom));
    endtask

    // One SCL pulse carrying bit v; skipped once the clock budget is spent.
    task automatic clock_bit(logic v);
        if (clk_budget == 0)
            return;
        clk_budget--;
        add_event(i2csbf_pkg::OP_SCL, 8'($urandom), 1'b0);
        if ($urandom_range(99) < mix_pct)
            add_event($urandom_range(1) ? i2csbf_pkg::OP_PUSH : i2csbf_pkg::OP_POP,
                      8'($urandom), 1'($urandom));
        set_sda(v);
        add_event(i2csbf_pkg::OP_SCL, 8'($urandom), 1'b1);
    endtask

    task automatic queue_start();
        if (!(gen_scl && gen_sda))
        begin
            if (gen_scl)
                add_event(i2csbf_pkg::OP_SCL, 8'($urandom), 1'b0);
            set_sda(1'b1);
            add_event(i2csbf_pkg::OP_SCL, 8'($urandom), 1'b1);
        end
        add_event(i2csbf_pkg::OP_SDA, 8'($urandom), 1'b0);
    endtask

    task automatic queue_stop();
        if (gen_scl)
            add_event(i2csbf_pkg::OP_SCL, 8'($urandom), 1'b0);
        set_sda(1'b0);
        add_event(i2csbf_pkg::OP_SCL, 8'($urandom), 1'b1);
        add_event(i2csbf_pkg::OP_SDA, 8'($urandom), 1'b1);
    endtask

    // START, address, R/W and ACK, then nbytes bytes, each with its ACK; a read NACKs the last.
    task automatic queue_transfer(logic [6:0] addr, logic rd, int nbytes, int cut);
        logic [7:0] hdr;
        logic [7:0] b;
        hdr        = {addr, rd};
        clk_budget = cut;
        transfers++;
        if (rd)
            reads++;
        queue_start();
        for (int k = 7; k >= 0; k--)
            clock_bit(hdr[k]);
        clock_bit(1'b0);
        for (int n = 0; n < nbytes; n++)
        begin
            b = 8'($urandom);
            for (int k = 7; k >= 0; k--)
                clock_bit(b[k]);
            clock_bit(rd ? (n == nbytes - 1) : 1'b0);
        end
        // Leave some transfers open so the next one makes a repeated START.
        if ($urandom_range(99) < 80)
            queue_stop();
    endtask

    task automatic queue_random(int target);
        int   first;
        int   r;
        int   n;
        logic rd;
        logic [6:0] addr;
        first = event_q.size();
        while (event_q.size() - first < target)
        begin
            r = $urandom_range(99);
            if (r < 60)
            begin
                n    = $urandom_range(1, 4);
                rd   = 1'($urandom);
                addr = ($urandom_range(99) < 85) ? cur_addr
                                                  : cur_addr ^ 7'($urandom_range(1, 127));
                queue_transfer(addr, rd, n,
                               ($urandom_range(99) < 12) ? $urandom_range(1, 9 * (n + 1))
                                                          : 9 * (n + 1));
            end
            else if (r < 72)
                cpu_burst(i2csbf_pkg::OP_PUSH, $urandom_range(1, FIFO_ENTRIES + 2));
            else if (r < 84)
                cpu_burst(i2csbf_pkg::OP_POP, $urandom_range(1, FIFO_ENTRIES + 2));
            else if (r < 87)
                add_event(i2csbf_pkg::OP_FLUSH, 8'($urandom), 1'($urandom));
            else
            begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    add_event(3'($urandom_range(7)), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic queue_directed();
        add_event(i2csbf_pkg::OP_POP, 8'h00, 1'b0);
        add_event(i2csbf_pkg::OP_PUSH, 8'h00, 1'b0);
        add_event(i2csbf_pkg::OP_PUSH, 8'hFF, 1'b1);
        add_event(i2csbf_pkg::OP_POP, 8'hFF, 1'b1);
        for (int k = 0; k < SPARE_OPS; k++)
            add_event(OP_SPARE_FIRST + 3'(k), 8'hFF, 1'b1);
        // Same levels again: no edge.
        add_event(i2csbf_pkg::OP_SCL, 8'h00, 1'b1);
        add_event(i2csbf_pkg::OP_SDA, 8'h00, 1'b1);
        add_event(i2csbf_pkg::OP_FLUSH, 8'hA5, 1'b0);
        // START followed straight by STOP.
        add_event(i2csbf_pkg::OP_SDA, 8'h00, 1'b0);
        add_event(i2csbf_pkg::OP_SDA, 8'h00, 1'b1);
        // SDA moves while SCL is low: no START or STOP.
        add_event(i2csbf_pkg::OP_SCL, 8'h00, 1'b0);
        add_event(i2csbf_pkg::OP_SDA, 8'h00, 1'b0);
        add_event(i2csbf_pkg::OP_SDA, 8'h00, 1'b1);
        add_event(i2csbf_pkg::OP_SCL, 8'h00, 1'b1);
        // Fill TX past full, then read with an empty TX FIFO (underrun) and a NACK.
        cpu_burst(i2csbf_pkg::OP_PUSH, FIFO_ENTRIES + 1);
        add_event(i2csbf_pkg::OP_FLUSH, 8'h00, 1'b0);
        mix_pct = 0;
        queue_transfer(cur_addr, 1'b1, 2, 27);
        queue_transfer(cur_addr ^ 7'h01, 1'b0, 1, 18);
        mix_pct = 8;
    endtask

    task automatic send_events();
        bus_event_t e;
        while (event_q.size() > 0)
        begin
            e = event_q.pop_front();
            while ($urandom_range(99) < send_idle)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid   <= 1'b1;
            operation  <= e.op;
            push_byte  <= e.data;
            line_level <= e.lv;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            tracker.note_event(e.op, e.data, e.lv);
            events_sent++;
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_address(logic [6:0] a);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_data  <= a;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.set_address(a);
        cur_addr = a;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_address(7'h00);
        send_idle = 13;
        recv_idle = 79;
        queue_directed();
        queue_random(110);
        send_events();

        write_address(7'h7F);
        send_idle = 79;
        recv_idle = 13;
        queue_random(130);
        send_events();

        write_address(7'($urandom_range(1, 126)));
        send_idle = 0;
        recv_idle = 0;
        // Long write with no pops drives the RX FIFO past full.
        mix_pct = 0;
        queue_transfer(cur_addr, 1'b0, FIFO_ENTRIES + 1, 9 * (FIFO_ENTRIES + 2));
        mix_pct = 8;
        queue_random(15);
        send_events();

        wait_drained();
        $display("%0d events sent, %0d result beats checked, %0d mismatches",
                 events_sent, tracker.checked, tracker.errors);
        $display("%0d bus transfers (%0d reads) over addresses 0x00, 0x7f and 0x%h",
                 transfers, reads, cur_addr);
        if (tracker.errors == 0 && tracker.pending() == 0)
        begin
            $display("i2c_slave_with_byte_fifos regression: pass");
        end
        else
        begin
            $display("i2c_slave_with_byte_fifos regression: fail");
        end
        $finish;
    end

endmodule
